@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SMCP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SMCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/smcp_pkg.sv @@
// ----------------------------------------------------------------------------
// smcp_pkg
// Shared types and constants of the status message character parser.
// ----------------------------------------------------------------------------
package smcp_pkg;

  localparam int unsigned CodeW = 8;

  typedef struct packed {
    logic             message_done;
    logic [CodeW-1:0] radio;
    logic [CodeW-1:0] system;
    logic [CodeW-1:0] storage;
  } result_t;

endpackage

@@ hdl/smcp_core.sv @@
// ----------------------------------------------------------------------------
// smcp_core
// Parse state and status codes; one character per step, result is the
// post-step view of the status codes plus the message completion flag.
// ----------------------------------------------------------------------------
module smcp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        ch_i,
  output smcp_pkg::result_t res_o
);
  import smcp_pkg::*;

  localparam logic [2:0] PhWaitBrace = 3'd0;
  localparam logic [2:0] PhWaitQuote = 3'd1;
  localparam logic [2:0] PhKeyOne    = 3'd2;
  localparam logic [2:0] PhKeyTwo    = 3'd3;
  localparam logic [2:0] PhKeyThree  = 3'd4;
  localparam logic [2:0] PhEndQuote  = 3'd5;
  localparam logic [2:0] PhWaitColon = 3'd6;
  localparam logic [2:0] PhValue     = 3'd7;

  localparam logic [7:0] ChLBrace   = 8'h7B;
  localparam logic [7:0] ChRBrace   = 8'h7D;
  localparam logic [7:0] ChColon    = 8'h3A;
  localparam logic [7:0] ChComma    = 8'h2C;
  localparam logic [7:0] ChQuote    = 8'h22;
  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] ChTab      = 8'h09;
  localparam logic [7:0] ChZero     = 8'h30;
  localparam logic [7:0] ChNine     = 8'h39;
  localparam logic [7:0] KeyStorage = 8'h54;
  localparam logic [7:0] KeySystem  = 8'h59;
  localparam logic [7:0] KeyRadio   = 8'h44;

  logic [2:0]       phase_q, phase_d;
  logic [7:0]       key_q, key_d;
  logic [CodeW-1:0] acc_q, acc_d;
  logic [CodeW-1:0] storage_q, storage_d;
  logic [CodeW-1:0] system_q, system_d;
  logic [CodeW-1:0] radio_q, radio_d;

  logic             blank;
  logic             digit;
  logic [3:0]       digit_val;
  logic [11:0]      acc_ext;
  logic [11:0]      acc_sum;
  logic [CodeW-1:0] acc_sat;
  logic             commit;
  logic             done;

  assign blank     = (ch_i == ChSpace) || (ch_i == ChTab);
  assign digit     = (ch_i >= ChZero) && (ch_i <= ChNine);
  assign digit_val = ch_i[3:0];
  assign acc_ext   = {4'b0000, acc_q};
  assign acc_sum   = (acc_ext << 3) + (acc_ext << 1) + {8'b0, digit_val};
  assign acc_sat   = (acc_sum > 12'd255) ? 8'hFF : acc_sum[7:0];

  always_comb begin
    phase_d = phase_q;
    key_d   = key_q;
    acc_d   = acc_q;
    commit  = 1'b0;
    done    = 1'b0;
    unique case (phase_q)
      PhWaitBrace: begin
        phase_d = (ch_i == ChLBrace) ? PhWaitQuote : PhWaitBrace;
      end
      PhWaitQuote: begin
        if (ch_i == ChQuote) begin
          phase_d = PhKeyOne;
        end else if (!blank) begin
          phase_d = PhWaitBrace;
        end
      end
      PhKeyOne: begin
        phase_d = PhKeyTwo;
      end
      PhKeyTwo: begin
        key_d   = ch_i;
        phase_d = PhKeyThree;
      end
      PhKeyThree: begin
        phase_d = PhEndQuote;
      end
      PhEndQuote: begin
        phase_d = (ch_i == ChQuote) ? PhWaitColon : PhWaitQuote;
      end
      PhWaitColon: begin
        if (ch_i == ChColon) begin
          acc_d   = '0;
          phase_d = PhValue;
        end else if (!blank) begin
          phase_d = PhWaitQuote;
        end
      end
      PhValue: begin
        if (digit) begin
          acc_d = acc_sat;
        end else if (blank) begin
          phase_d = PhValue;
        end else if (ch_i == ChComma) begin
          commit  = 1'b1;
          phase_d = PhWaitQuote;
        end else if (ch_i == ChRBrace) begin
          commit  = 1'b1;
          done    = 1'b1;
          phase_d = PhWaitBrace;
        end else begin
          phase_d = PhWaitBrace;
        end
      end
    endcase
  end

  always_comb begin
    storage_d = storage_q;
    system_d  = system_q;
    radio_d   = radio_q;
    if (commit) begin
      if (key_q == KeyStorage) begin
        storage_d = acc_q;
      end else if (key_q == KeySystem) begin
        system_d = acc_q;
      end else if (key_q == KeyRadio) begin
        radio_d = acc_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhWaitBrace;
      key_q     <= '0;
      acc_q     <= '0;
      storage_q <= '0;
      system_q  <= '0;
      radio_q   <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      key_q     <= key_d;
      acc_q     <= acc_d;
      storage_q <= storage_d;
      system_q  <= system_d;
      radio_q   <= radio_d;
    end
  end

  assign res_o.message_done = done;
  assign res_o.storage      = storage_d;
  assign res_o.system       = system_d;
  assign res_o.radio        = radio_d;

endmodule

@@ hdl/status_message_char_parser.sv @@
// ----------------------------------------------------------------------------
// status_message_char_parser
// Status message parser: one character word in, one status word out.
//
//   channel  dir  tdata fields (low bit up)                tlast
//   s_axis   in   ch[7:0]                                  -
//   m_axis   out  storage[7:0] system[15:8] radio[23:16]   message_done
//
// One character per cycle while s_axis_tready_o is high; each result is
// registered in the result register, or in the skid entry during a stall.
// A two-entry output (result register plus skid) keeps input flowing during
// an output stall until the skid fills; s_axis_tready_o drops only with both full.
// Reset clears the parser to brace search and all status codes to zero.
// ----------------------------------------------------------------------------
module status_message_char_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // ch[7:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // storage[7:0], system[15:8], radio[23:16]
  output logic        m_axis_tlast_o    // message_done
);
  import smcp_pkg::*;

  logic    in_fire;
  result_t res;
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;

  assign s_axis_tready_o = !skid_valid_q;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  smcp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_fire),
    .ch_i   (s_axis_tdata_i),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      out_valid_q  <= skid_valid_q || in_fire;
      skid_valid_q <= 1'b0;
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready_i) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.radio, out_q.system, out_q.storage};
  assign m_axis_tlast_o  = out_q.message_done;

endmodule

@@ hdl/smcp_checker.sv @@
// ----------------------------------------------------------------------------
// smcp_checker
// Port-level checks of the status message parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smcp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  logic in_fire;
  logic out_stall;

  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;

  `SMCP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall,
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o),
    "stalled output word changed")
  `SMCP_ASSERT_NEXT(a_in_to_out, clk_i, rst_ni, in_fire, m_axis_tvalid_o,
    "accepted word produced no result")
  `SMCP_ASSERT_NEXT(a_no_invent, clk_i, rst_ni, !m_axis_tvalid_o && !in_fire,
    !m_axis_tvalid_o, "result without input word")
  `SMCP_ASSERT_NOW(a_ready_low, clk_i, rst_ni, !s_axis_tready_o, m_axis_tvalid_o,
    "input blocked with empty output")

endmodule

bind status_message_char_parser smcp_checker u_smcp_checker (.*);

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the status message character parser. A directed
// list of characters walks brace search, key capture, blanks, saturation,
// empty values and an abort. Random messages follow, mostly well formed with
// some corrupted characters and noise between them. Output words are checked
// against listed words or a cycle-free model of parse state and status codes.
// ----------------------------------------------------------------------------
module tb;
  import smcp_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned TargetWords = 1300;
  localparam int unsigned DirRows     = 25;

  localparam logic [7:0] ChLBrace = 8'h7B;
  localparam logic [7:0] ChRBrace = 8'h7D;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChBang   = 8'h21;
  localparam logic [7:0] KeyStorage = 8'h54;
  localparam logic [7:0] KeySystem  = 8'h59;
  localparam logic [7:0] KeyRadio   = 8'h44;

  typedef enum logic [2:0] {
    SeekBrace, SeekQuote, KeyFirst, KeySecond, KeyThird, CloseQuote, SeekColon, ReadValue
  } phase_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       known;
    result_t    res;
  } dir_row_t;

  localparam result_t Quiet = '0;

  dir_row_t dir_rows [DirRows] = '{
    '{8'h00,      1'b1, Quiet},
    '{8'hFF,      1'b1, Quiet},
    '{ChLBrace,   1'b0, Quiet},
    '{ChQuote,    1'b0, Quiet},
    '{8'h78,      1'b0, Quiet},
    '{KeyStorage, 1'b0, Quiet},
    '{8'h78,      1'b0, Quiet},
    '{ChQuote,    1'b0, Quiet},
    '{ChColon,    1'b0, Quiet},
    '{ChSpace,    1'b0, Quiet},
    '{ChNine,     1'b0, Quiet},
    '{ChNine,     1'b0, Quiet},
    '{ChNine,     1'b0, Quiet},
    '{ChRBrace,   1'b1, result_t'{1'b1, 8'd0, 8'd0, 8'd255}},
    '{ChLBrace,   1'b0, Quiet},
    '{ChQuote,    1'b0, Quiet},
    '{8'h51,      1'b0, Quiet},
    '{KeySystem,  1'b0, Quiet},
    '{8'h51,      1'b0, Quiet},
    '{ChQuote,    1'b0, Quiet},
    '{ChColon,    1'b0, Quiet},
    '{ChRBrace,   1'b1, result_t'{1'b1, 8'd0, 8'd0, 8'd255}},
    '{ChLBrace,   1'b0, Quiet},
    '{ChTab,      1'b0, Quiet},
    '{ChBang,     1'b1, result_t'{1'b0, 8'd0, 8'd0, 8'd255}}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = '0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  phase_e      phase_q = SeekBrace;
  logic [7:0]  key_q = '0;
  logic [7:0]  acc_q = '0;
  logic [7:0]  storage_q = '0;
  logic [7:0]  system_q = '0;
  logic [7:0]  radio_q = '0;

  result_t     pending_status[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  int unsigned burst_left = 0;
  int unsigned rx_cycle = 0;

  status_message_char_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic is_blank(input logic [7:0] c);
    return c == ChSpace || c == ChTab;
  endfunction

  function automatic void store_code();
    if (key_q == KeyStorage) storage_q = acc_q;
    else if (key_q == KeySystem) system_q = acc_q;
    else if (key_q == KeyRadio) radio_q = acc_q;
  endfunction

  function automatic result_t parse_char(input logic [7:0] c);
    int unsigned v;
    logic        done;
    done = 1'b0;
    case (phase_q)
      SeekBrace: phase_q = (c == ChLBrace) ? SeekQuote : SeekBrace;
      SeekQuote: begin
        if (c == ChQuote) phase_q = KeyFirst;
        else if (!is_blank(c)) phase_q = SeekBrace;
      end
      KeyFirst: phase_q = KeySecond;
      KeySecond: begin
        key_q = c;
        phase_q = KeyThird;
      end
      KeyThird: phase_q = CloseQuote;
      CloseQuote: phase_q = (c == ChQuote) ? SeekColon : SeekQuote;
      SeekColon: begin
        if (c == ChColon) begin
          acc_q = '0;
          phase_q = ReadValue;
        end else if (!is_blank(c)) begin
          phase_q = SeekQuote;
        end
      end
      default: begin
        if (c >= ChZero && c <= ChNine) begin
          v = acc_q * 10 + (c - ChZero);
          acc_q = (v > 255) ? 8'd255 : v[7:0];
        end else if (is_blank(c)) begin
        end else if (c == ChComma) begin
          store_code();
          phase_q = SeekQuote;
        end else if (c == ChRBrace) begin
          store_code();
          phase_q = SeekBrace;
          done = 1'b1;
        end else begin
          phase_q = SeekBrace;
        end
      end
    endcase
    return result_t'{done, radio_q, system_q, storage_q};
  endfunction

  task automatic send_char(input logic [7:0] c, input logic known, input result_t res);
    result_t pred;
    if (burst_left == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(8, 20) : $urandom_range(1, 4))
        @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data  <= c;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pred = parse_char(c);
    pending_status.push_back(known ? res : pred);
  endtask

  task automatic put(input logic [7:0] c);
    logic [7:0] w;
    w = ($urandom_range(0, 39) == 0) ? 8'($urandom_range(0, 255)) : c;
    send_char(w, 1'b0, Quiet);
    words_sent++;
  endtask

  task automatic pad();
    int unsigned n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) put($urandom_range(0, 1) ? ChSpace : ChTab);
  endtask

  task automatic send_message();
    int unsigned fields;
    int unsigned digits;
    logic [7:0]  key;
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)), 1'b0, Quiet);
    put(ChLBrace);
    fields = $urandom_range(1, 4);
    for (int f = 0; f < fields; f++) begin
      case ($urandom_range(0, 4))
        0: key = KeyStorage;
        1: key = KeySystem;
        2: key = KeyRadio;
        3: key = ($urandom_range(0, 1)) ? KeyStorage : KeyRadio;
        default: key = 8'($urandom_range(0, 255));
      endcase
      pad();
      put(ChQuote);
      put(8'($urandom_range(0, 255)));
      put(key);
      put(8'($urandom_range(0, 255)));
      put(ChQuote);
      pad();
      put(ChColon);
      pad();
      digits = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
      repeat (digits) put(ChZero + 8'($urandom_range(0, 9)));
      pad();
      put((f == fields - 1) ? ChRBrace : ChComma);
    end
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_status.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] act);
    if (exp !== act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      case ((rx_cycle / 97) % 4)
        0: m_ready <= 1'b1;
        1: m_ready <= 1'($urandom_range(0, 1));
        2: m_ready <= (rx_cycle % 4) != 0;
        default: m_ready <= $urandom_range(0, 5) == 0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t exp;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got = result_t'({m_axis_tlast_o, m_axis_tdata_o});
      if (pending_status.size() == 0) begin
        $error("status word with nothing pending: %h", got);
        mismatches++;
      end else begin
        exp = pending_status.pop_front();
        check_field("message_done", 8'(exp.message_done), 8'(got.message_done));
        check_field("storage", exp.storage, got.storage);
        check_field("system", exp.system, got.system);
        check_field("radio", exp.radio, got.radio);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned msg_count;
    msg_count = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < DirRows; i++)
      send_char(dir_rows[i].ch, dir_rows[i].known, dir_rows[i].res);
    drain();
    while (words_sent < TargetWords) begin
      send_message();
      msg_count++;
      if (msg_count == 40 || msg_count == 120) drain();
    end
    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
